// ----- design/dcs_pkg.sv -----
// Shared types, operation schedule and latency helpers for the damped Cholesky solver.
`default_nettype none

package dcs_pkg;

  // Width and reset value of the pivot floor register.
  localparam int FLOOR_W = 17;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 17'd1;

  // Cycles through one pipelined multiplier.
  localparam int MUL_LAT = 4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_ROOT
  } op_kind_t;

  // Slots of the value vector that travels down the pipeline.
  typedef enum logic [5:0] {
    V_M00, V_M11, V_M22, V_M10, V_M20, V_M21, V_DMP, V_BX, V_BY, V_BZ,
    V_A00, V_A11, V_A22, V_L00, V_L10, V_L20, V_Z0,
    V_P1, V_P2, V_P3, V_P4, V_P5,
    V_S1, V_S2, V_S3, V_S4, V_S5,
    V_L11, V_L21, V_Z1, V_Q1, V_Q2, V_T1, V_T2,
    V_L22, V_Z2, V_Y2, V_R1, V_U1, V_Y1,
    V_V1, V_V2, V_W1, V_W2, V_Y0
  } slot_t;

  localparam int NV = int'(V_Y0) + 1;

  typedef struct packed {
    logic [4:0] phase;
    op_kind_t   kind;
    slot_t      src_a;
    slot_t      src_b;
    slot_t      dst;
  } op_desc_t;

  localparam int NPH  = 19;
  localparam int NOPS = 35;

  // Kind of unit used by each phase, first phase first.
  localparam op_kind_t PH_KIND [NPH] = '{
    OP_ADD, OP_ROOT, OP_DIV, OP_MUL, OP_SUB, OP_ROOT, OP_DIV, OP_MUL, OP_SUB,
    OP_ROOT, OP_DIV, OP_DIV, OP_MUL, OP_SUB, OP_DIV, OP_MUL, OP_SUB, OP_SUB, OP_DIV
  };

  // Each operation reads its operands from the value vector entering its phase.
  localparam op_desc_t OPS [NOPS] = '{
    '{5'd1,  OP_ADD,  V_M00, V_DMP, V_A00},
    '{5'd1,  OP_ADD,  V_M11, V_DMP, V_A11},
    '{5'd1,  OP_ADD,  V_M22, V_DMP, V_A22},
    '{5'd2,  OP_ROOT, V_A00, V_A00, V_L00},
    '{5'd3,  OP_DIV,  V_M10, V_L00, V_L10},
    '{5'd3,  OP_DIV,  V_M20, V_L00, V_L20},
    '{5'd3,  OP_DIV,  V_BX,  V_L00, V_Z0},
    '{5'd4,  OP_MUL,  V_L10, V_L10, V_P1},
    '{5'd4,  OP_MUL,  V_L20, V_L10, V_P2},
    '{5'd4,  OP_MUL,  V_L20, V_L20, V_P3},
    '{5'd4,  OP_MUL,  V_L10, V_Z0,  V_P4},
    '{5'd4,  OP_MUL,  V_L20, V_Z0,  V_P5},
    '{5'd5,  OP_SUB,  V_A11, V_P1,  V_S1},
    '{5'd5,  OP_SUB,  V_M21, V_P2,  V_S2},
    '{5'd5,  OP_SUB,  V_A22, V_P3,  V_S3},
    '{5'd5,  OP_SUB,  V_BY,  V_P4,  V_S4},
    '{5'd5,  OP_SUB,  V_BZ,  V_P5,  V_S5},
    '{5'd6,  OP_ROOT, V_S1,  V_S1,  V_L11},
    '{5'd7,  OP_DIV,  V_S2,  V_L11, V_L21},
    '{5'd7,  OP_DIV,  V_S4,  V_L11, V_Z1},
    '{5'd8,  OP_MUL,  V_L21, V_L21, V_Q1},
    '{5'd8,  OP_MUL,  V_L21, V_Z1,  V_Q2},
    '{5'd9,  OP_SUB,  V_S3,  V_Q1,  V_T1},
    '{5'd9,  OP_SUB,  V_S5,  V_Q2,  V_T2},
    '{5'd10, OP_ROOT, V_T1,  V_T1,  V_L22},
    '{5'd11, OP_DIV,  V_T2,  V_L22, V_Z2},
    '{5'd12, OP_DIV,  V_Z2,  V_L22, V_Y2},
    '{5'd13, OP_MUL,  V_L21, V_Y2,  V_R1},
    '{5'd14, OP_SUB,  V_Z1,  V_R1,  V_U1},
    '{5'd15, OP_DIV,  V_U1,  V_L11, V_Y1},
    '{5'd16, OP_MUL,  V_L10, V_Y1,  V_V1},
    '{5'd16, OP_MUL,  V_L20, V_Y2,  V_V2},
    '{5'd17, OP_SUB,  V_Z0,  V_V1,  V_W1},
    '{5'd18, OP_SUB,  V_W1,  V_V2,  V_W2},
    '{5'd19, OP_DIV,  V_W2,  V_L00, V_Y0}
  };

  function automatic int phase_lat(op_kind_t k, int w, int f);
    case (k)
      OP_MUL:  return MUL_LAT;
      OP_DIV:  return w + f + 2;
      OP_ROOT: return ((w + f + 1) >> 1) + 2;
      default: return 1;
    endcase
  endfunction

  // Cycles from an accepted word to its done strobe, output register included.
  function automatic int pipe_lat(int w, int f);
    int s = 1;
    for (int i = 0; i < NPH; i++) begin
      s += phase_lat(PH_KIND[i], w, f);
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- design/dcs_delay.sv -----
// Delay line that carries a value vector and its valid bit through a fixed number of cycles.
`default_nettype none

module dcs_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [DEPTH-1:0] vld_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q[0] <= in_valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    data_q[0] <= in_data;
    for (int i = 1; i < DEPTH; i++) begin
      data_q[i] <= data_q[i-1];
    end
  end

  assign out_valid = vld_q[DEPTH-1];
  assign out_data  = data_q[DEPTH-1];

endmodule

`default_nettype wire

// ----- design/dcs_addsub.sv -----
// Saturating fixed point adder and subtractor with one register.
`default_nettype none

module dcs_addsub #(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] r,
  output logic         sat
);

  logic [W:0] ax;
  logic [W:0] bx;
  logic [W:0] sum;
  logic       ov;

  assign ax  = {a[W-1], a};
  assign bx  = sub ? (~{b[W-1], b} + 1'b1) : {b[W-1], b};
  assign sum = ax + bx;
  assign ov  = sum[W] != sum[W-1];

  always_ff @(posedge clk) begin
    sat <= ov;
    r   <= ov ? {sum[W], {(W-1){~sum[W]}}} : sum[W-1:0];
  end

endmodule

`default_nettype wire

// ----- design/dcs_mul.sv -----
// Four-stage saturating fixed point multiplier built from half-width partial products.
`default_nettype none

module dcs_mul #(
  parameter int W = 48,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] r,
  output logic         sat
);

  localparam int H = (W + 1) / 2;
  localparam int U = W - H;

  logic [W-1:0]     am;
  logic [W-1:0]     bm;
  logic             neg1;
  logic [2*H-1:0]   p00;
  logic [H+U-1:0]   p01;
  logic [H+U-1:0]   p10;
  logic [2*U-1:0]   p11;
  logic             neg2;
  logic [2*W-1:0]   full;
  logic [2*W-1:0]   prod;
  logic             neg3;
  logic [2*W-1:0]   lim;
  logic             ov;
  logic [W-1:0]     mag;

  always_ff @(posedge clk) begin
    neg1 <= a[W-1] ^ b[W-1];
    am   <= a[W-1] ? (~a + 1'b1) : a;
    bm   <= b[W-1] ? (~b + 1'b1) : b;
  end

  always_ff @(posedge clk) begin
    neg2 <= neg1;
    p00  <= am[H-1:0] * bm[H-1:0];
    p01  <= am[H-1:0] * bm[W-1:H];
    p10  <= am[W-1:H] * bm[H-1:0];
    p11  <= am[W-1:H] * bm[W-1:H];
  end

  assign full = (2*W)'(p00) + ((2*W)'(p01) << H) + ((2*W)'(p10) << H)
              + ((2*W)'(p11) << (2*H));

  always_ff @(posedge clk) begin
    neg3 <= neg2;
    prod <= full >> F;
  end

  // The negative side reaches one further than the positive side.
  assign lim = (2*W)'({1'b0, {(W-1){1'b1}}}) + (2*W)'(neg3);
  assign ov  = prod > lim;
  assign mag = ov ? lim[W-1:0] : prod[W-1:0];

  always_ff @(posedge clk) begin
    sat <= ov;
    r   <= neg3 ? (~mag + 1'b1) : mag;
  end

endmodule

`default_nettype wire

// ----- design/dcs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating fixed point result.
`default_nettype none

module dcs_div #(
  parameter int W = 48,
  parameter int F = 16
) (
  input  logic         clk,
  input  logic [W-1:0] a,
  input  logic [W-1:0] d,
  output logic [W-1:0] r,
  output logic         sat
);

  localparam int NB = W + F;

  logic [W-1:0]  rem [NB+1];
  logic [NB-1:0] num [NB+1];
  logic [NB-1:0] quo [NB+1];
  logic [W-1:0]  den [NB+1];
  logic          neg [NB+1];
  logic [W-1:0]  amag;
  logic [NB-1:0] lim;
  logic          ov;
  logic [W-1:0]  mag;

  assign amag = a[W-1] ? (~a + 1'b1) : a;

  always_ff @(posedge clk) begin
    neg[0] <= a[W-1] ^ d[W-1];
    num[0] <= {amag, {F{1'b0}}};
    den[0] <= d[W-1] ? (~d + 1'b1) : d;
    rem[0] <= '0;
    quo[0] <= '0;
  end

  for (genvar k = 1; k <= NB; k++) begin : g_stage
    logic [W:0] trial;
    logic       ge;

    assign trial = {rem[k-1], num[k-1][NB-1]};
    assign ge    = trial >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      rem[k] <= ge ? W'(trial - {1'b0, den[k-1]}) : trial[W-1:0];
      quo[k] <= {quo[k-1][NB-2:0], ge};
      num[k] <= num[k-1] << 1;
      den[k] <= den[k-1];
      neg[k] <= neg[k-1];
    end
  end

  assign lim = NB'({1'b0, {(W-1){1'b1}}}) + NB'(neg[NB]);
  assign ov  = quo[NB] > lim;
  assign mag = ov ? lim[W-1:0] : quo[NB][W-1:0];

  always_ff @(posedge clk) begin
    sat <= ov;
    r   <= neg[NB] ? (~mag + 1'b1) : mag;
  end

endmodule

`default_nettype wire

// ----- design/dcs_root.sv -----
// Pipelined square root of a floored pivot, two radicand bits per stage.
`default_nettype none

module dcs_root
  import dcs_pkg::*;
#(
  parameter int W = 48,
  parameter int F = 16
) (
  input  logic               clk,
  input  logic [W-1:0]       a,
  input  logic [FLOOR_W-1:0] flr,
  output logic [W-1:0]       r,
  output logic               sat
);

  localparam int RB = (W + F + 1) / 2;
  localparam int XB = 2 * RB;
  localparam int CW = RB + W;

  logic [RB+1:0]      rem  [RB+1];
  logic [RB-1:0]      root [RB+1];
  logic [XB-1:0]      xs   [RB+1];
  logic [FLOOR_W-1:0] fl;
  logic [W-1:0]       mag;
  logic [W-1:0]       arg;
  logic [CW-1:0]      lim;
  logic               ov;

  // A floor of zero acts as one so that no divisor downstream is zero.
  assign fl  = (flr == '0) ? FLOOR_W'(1) : flr;
  assign mag = a[W-1] ? (~a + 1'b1) : a;
  assign arg = (a[W-1] || (mag < W'(fl))) ? W'(fl) : mag;

  always_ff @(posedge clk) begin
    xs[0]   <= XB'({arg, {F{1'b0}}});
    rem[0]  <= '0;
    root[0] <= '0;
  end

  for (genvar k = 1; k <= RB; k++) begin : g_stage
    logic [RB+1:0] cand;
    logic [RB+1:0] trial;
    logic          ge;

    assign cand  = {rem[k-1][RB-1:0], xs[k-1][XB-1 -: 2]};
    assign trial = {root[k-1], 2'b01};
    assign ge    = cand >= trial;

    always_ff @(posedge clk) begin
      rem[k]  <= ge ? (cand - trial) : cand;
      root[k] <= {root[k-1][RB-2:0], ge};
      xs[k]   <= xs[k-1] << 2;
    end
  end

  assign lim = CW'({1'b0, {(W-1){1'b1}}});
  assign ov  = CW'(root[RB]) > lim;

  always_ff @(posedge clk) begin
    sat <= ov;
    r   <= ov ? lim[W-1:0] : W'(root[RB]);
  end

endmodule

`default_nettype wire

// ----- design/damped_cholesky_solve_3x3_top.sv -----
// Top level of the damped 3x3 Cholesky solver: phase pipeline, config register and outputs.
// At the default 48-bit Q31.16 format the six serial divider phases make up most of the
// pipeline depth from start to done.
// Throughput: one word per cycle, since busy is low at all times outside reset.
// Reset: rst is synchronous and active high; it drops every word in flight, holds busy high
// while asserted and returns pivot_floor to one. Results cannot be held off by the receiver.
`default_nettype none

module damped_cholesky_solve_3x3_top
  import dcs_pkg::*;
#(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_WIDTH-1:0] m00,
  input  logic signed [VALUE_WIDTH-1:0] m11,
  input  logic signed [VALUE_WIDTH-1:0] m22,
  input  logic signed [VALUE_WIDTH-1:0] m10,
  input  logic signed [VALUE_WIDTH-1:0] m20,
  input  logic signed [VALUE_WIDTH-1:0] m21,
  input  logic        [VALUE_WIDTH-2:0] damping_squared,
  input  logic signed [VALUE_WIDTH-1:0] b_x,
  input  logic signed [VALUE_WIDTH-1:0] b_y,
  input  logic signed [VALUE_WIDTH-1:0] b_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic        [FLOOR_W-1:0]     cfg_data,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] y0,
  output logic signed [VALUE_WIDTH-1:0] y1,
  output logic signed [VALUE_WIDTH-1:0] y2,
  output logic                          solution_valid
);

  // Every word travels as one vector of value slots plus a sticky saturation flag.
  // A phase delays the whole vector by the latency of its unit, and the units of
  // that phase overwrite their destination slots at the far end.
  typedef logic [NV-1:0][VALUE_WIDTH-1:0] vals_t;

  localparam int PW = NV * VALUE_WIDTH + 1;

  vals_t                  pv   [NPH+1];
  logic [NPH:0]           psat;
  logic [NPH:0]           pvld;
  logic [VALUE_WIDTH-1:0] ores [NOPS];
  logic [NOPS-1:0]        osat;
  logic [FLOOR_W-1:0]     pivot_floor;
  vals_t                  vin;

  // The pipeline never stalls, so only reset keeps a word out.
  assign busy      = rst;
  assign cfg_ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_floor <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pivot_floor <= cfg_data;
    end
  end

  // Load the input fields into their slots; damping is unsigned and zero extended.
  always_comb begin
    vin        = '0;
    vin[V_M00] = m00;
    vin[V_M11] = m11;
    vin[V_M22] = m22;
    vin[V_M10] = m10;
    vin[V_M20] = m20;
    vin[V_M21] = m21;
    vin[V_DMP] = {1'b0, damping_squared};
    vin[V_BX]  = b_x;
    vin[V_BY]  = b_y;
    vin[V_BZ]  = b_z;
  end

  assign pv[0]   = vin;
  assign psat[0] = 1'b0;
  assign pvld[0] = start & ~busy;

  // Arithmetic units, one per operation of the schedule.
  for (genvar i = 0; i < NOPS; i++) begin : g_op
    localparam int PH = int'(OPS[i].phase);
    if (OPS[i].kind == OP_MUL) begin : g_mul
      dcs_mul #(.W(VALUE_WIDTH), .F(FRACTION_BITS)) u_mul (
        .clk (clk),
        .a   (pv[PH-1][OPS[i].src_a]),
        .b   (pv[PH-1][OPS[i].src_b]),
        .r   (ores[i]),
        .sat (osat[i])
      );
    end else if (OPS[i].kind == OP_DIV) begin : g_div
      dcs_div #(.W(VALUE_WIDTH), .F(FRACTION_BITS)) u_div (
        .clk (clk),
        .a   (pv[PH-1][OPS[i].src_a]),
        .d   (pv[PH-1][OPS[i].src_b]),
        .r   (ores[i]),
        .sat (osat[i])
      );
    end else if (OPS[i].kind == OP_ROOT) begin : g_root
      dcs_root #(.W(VALUE_WIDTH), .F(FRACTION_BITS)) u_root (
        .clk (clk),
        .a   (pv[PH-1][OPS[i].src_a]),
        .flr (pivot_floor),
        .r   (ores[i]),
        .sat (osat[i])
      );
    end else begin : g_add
      dcs_addsub #(.W(VALUE_WIDTH)) u_add (
        .clk (clk),
        .a   (pv[PH-1][OPS[i].src_a]),
        .b   (pv[PH-1][OPS[i].src_b]),
        .sub (OPS[i].kind == OP_SUB),
        .r   (ores[i]),
        .sat (osat[i])
      );
    end
  end

  // Phase delay lines and the merge of each phase's results into the vector.
  for (genvar k = 1; k <= NPH; k++) begin : g_ph
    logic [PW-1:0] dl;
    vals_t         v;
    logic          s;

    dcs_delay #(
      .WIDTH (PW),
      .DEPTH (phase_lat(PH_KIND[k-1], VALUE_WIDTH, FRACTION_BITS))
    ) u_dly (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pvld[k-1]),
      .in_data   ({psat[k-1], pv[k-1]}),
      .out_valid (pvld[k]),
      .out_data  (dl)
    );

    always_comb begin
      v = dl[PW-2:0];
      s = dl[PW-1];
      for (int j = 0; j < NOPS; j++) begin
        if (int'(OPS[j].phase) == k) begin
          v[OPS[j].dst] = ores[j];
          s             = s | osat[j];
        end
      end
    end

    assign pv[k]   = v;
    assign psat[k] = s;
  end

  // Output register: results show for one cycle under the done strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pvld[NPH];
    end
  end

  always_ff @(posedge clk) begin
    if (pvld[NPH]) begin
      y0             <= pv[NPH][V_Y0];
      y1             <= pv[NPH][V_Y1];
      y2             <= pv[NPH][V_Y2];
      solution_valid <= ~psat[NPH];
    end
  end

endmodule

`default_nettype wire

// ----- design/dcs_checker.sv -----
// Port-level checks of the damped Cholesky solver and the bind that attaches them.
`default_nettype none

module dcs_checker
  import dcs_pkg::*;
#(
  parameter int VALUE_WIDTH   = 48,
  parameter int FRACTION_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic signed [VALUE_WIDTH-1:0] m00,
  input logic signed [VALUE_WIDTH-1:0] m11,
  input logic signed [VALUE_WIDTH-1:0] m22,
  input logic signed [VALUE_WIDTH-1:0] m10,
  input logic signed [VALUE_WIDTH-1:0] m20,
  input logic signed [VALUE_WIDTH-1:0] m21,
  input logic        [VALUE_WIDTH-2:0] damping_squared,
  input logic signed [VALUE_WIDTH-1:0] b_x,
  input logic signed [VALUE_WIDTH-1:0] b_y,
  input logic signed [VALUE_WIDTH-1:0] b_z,
  input logic                          cfg_ready,
  input logic                          done,
  input logic signed [VALUE_WIDTH-1:0] y0,
  input logic signed [VALUE_WIDTH-1:0] y1,
  input logic signed [VALUE_WIDTH-1:0] y2,
  input logic                          solution_valid
);

  localparam int LAT = pipe_lat(VALUE_WIDTH, FRACTION_BITS);

  logic zero_word;

  assign zero_word = start && !busy && m00 == 0 && m11 == 0 && m22 == 0 && m10 == 0
                  && m20 == 0 && m21 == 0 && damping_squared == 0 && b_x == 0
                  && b_y == 0 && b_z == 0;

  // A done strobe is always the tail of a word accepted exactly one latency earlier.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("done without a word accepted one latency earlier");

  // An all-zero word gives a zero solution without saturation, whatever the floor.
  a_zero_solution: assert property (@(posedge clk) disable iff (rst)
    zero_word |-> ##LAT (done && y0 == 0 && y1 == 0 && y2 == 0 && solution_valid))
    else $error("zero word did not give a clean zero solution");

  // Outside reset neither channel ever pushes back.
  a_never_blocks: assert property (@(posedge clk)
    !rst |-> (!busy && cfg_ready))
    else $error("block pushed back outside reset");

endmodule

bind damped_cholesky_solve_3x3_top dcs_checker #(
  .VALUE_WIDTH   (VALUE_WIDTH),
  .FRACTION_BITS (FRACTION_BITS)
) u_dcs_checker (.*);

`default_nettype wire

// ----- tb/damped_cholesky_solve_3x3_top_tb.sv -----
// Self-checking testbench for the damped 3x3 Cholesky solver top level.
`timescale 1ns / 100ps
`default_nettype none

module damped_cholesky_solve_3x3_top_tb
  import dcs_pkg::*;
();

  localparam int W = 48;
  localparam int F = 16;
  // Idle wait after the final drain, with generous margin over the start-to-done latency.
  localparam int DRAIN_CYCLES = 600;
  // The watchdog fires after this many cycles in which nothing is accepted.
  localparam int IDLE_LIMIT = 4000;

  // One input word of the solver.
  typedef struct {
    logic signed [W-1:0] m00, m11, m22, m10, m20, m21;
    logic        [W-2:0] damp;
    logic signed [W-1:0] bx, by, bz;
  } solve_word_t;

  // One expected solution.
  typedef struct {
    logic signed [W-1:0] y0, y1, y2;
    logic                ok;
  } solution_t;

  // Sign and magnitude value used by the predictor; each step rounds toward zero.
  typedef struct {
    bit          neg;
    bit [127:0]  mag;
  } sm_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [W-1:0] m00, m11, m22, m10, m20, m21, b_x, b_y, b_z;
  logic [W-2:0] damping_squared;
  logic cfg_valid;
  logic cfg_ready;
  logic [FLOOR_W-1:0] cfg_data;
  logic done;
  logic signed [W-1:0] y0, y1, y2;
  logic solution_valid;

  damped_cholesky_solve_3x3_top #(
    .VALUE_WIDTH(W),
    .FRACTION_BITS(F)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .m00(m00),
    .m11(m11),
    .m22(m22),
    .m10(m10),
    .m20(m20),
    .m21(m21),
    .damping_squared(damping_squared),
    .b_x(b_x),
    .b_y(b_y),
    .b_z(b_z),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .y0(y0),
    .y1(y1),
    .y2(y2),
    .solution_valid(solution_valid)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the pivot floor register and the predictor's saturation flag.
  logic [FLOOR_W-1:0] floor_copy;
  bit                 step_saturated;

  solution_t expected_solutions[$];
  int  words_sent;
  int  solutions_checked;
  int  invalid_seen;
  int  floors_used;
  int  error_count;
  int  idle_cycles;

  // ---------------------------------------------------------------------------
  // Predictor: every arithmetic step clamps to the 48-bit range and records
  // any clamp, which in turn clears the valid flag of the solution.
  // ---------------------------------------------------------------------------
  function automatic sm_t clamp_value(bit neg, bit [127:0] v);
    sm_t r;
    bit [127:0] lim;
    lim = neg ? (128'd1 << (W - 1)) : ((128'd1 << (W - 1)) - 1);
    if (v > lim) begin
      v = lim;
      step_saturated = 1'b1;
    end
    r.neg = (v != 0) ? neg : 1'b0;
    r.mag = v;
    return r;
  endfunction

  function automatic sm_t from_signed(logic [W-1:0] u);
    sm_t r;
    logic [W-1:0] n;
    // The negation stays within W bits, so the most negative value keeps magnitude 2^47.
    n     = W'(0) - u;
    r.neg = u[W-1];
    r.mag = 128'(u[W-1] ? n : u);
    return r;
  endfunction

  function automatic sm_t fx_plus(sm_t a, sm_t b);
    if (a.neg == b.neg) return clamp_value(a.neg, a.mag + b.mag);
    if (a.mag >= b.mag) return clamp_value(a.neg, a.mag - b.mag);
    return clamp_value(b.neg, b.mag - a.mag);
  endfunction

  function automatic sm_t fx_minus(sm_t a, sm_t b);
    if (b.mag != 0) b.neg = !b.neg;
    return fx_plus(a, b);
  endfunction

  function automatic sm_t fx_times(sm_t a, sm_t b);
    return clamp_value(a.neg ^ b.neg, (a.mag * b.mag) >> F);
  endfunction

  function automatic sm_t fx_over(sm_t a, sm_t d);
    if (d.mag == 0) return clamp_value(a.neg, {128{1'b1}});
    return clamp_value(a.neg ^ d.neg, (a.mag << F) / d.mag);
  endfunction

  // Square root of the argument, which is first raised to the pivot floor.
  function automatic sm_t pivot_sqrt(sm_t a);
    bit [127:0] fl;
    bit [127:0] x;
    bit [127:0] r;
    bit [127:0] c;
    fl = (floor_copy == 0) ? 128'd1 : 128'(floor_copy);
    if (a.neg || a.mag < fl) a.mag = fl;
    x = a.mag << F;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= x) r = c;
    end
    return clamp_value(1'b0, r);
  endfunction

  function automatic logic [W-1:0] to_signed(sm_t v);
    return v.neg ? (W'(0) - v.mag[W-1:0]) : v.mag[W-1:0];
  endfunction

  function automatic solution_t cholesky_solve(solve_word_t w);
    solution_t s;
    sm_t d, a00, a11, a22, l00, l10, l20, l11, l21, l22;
    sm_t z0, z1, z2, q0, q1, q2;
    step_saturated = 1'b0;
    d.neg = 1'b0;
    d.mag = 128'(w.damp);
    a00 = fx_plus(from_signed(w.m00), d);
    a11 = fx_plus(from_signed(w.m11), d);
    a22 = fx_plus(from_signed(w.m22), d);
    l00 = pivot_sqrt(a00);
    l10 = fx_over(from_signed(w.m10), l00);
    l20 = fx_over(from_signed(w.m20), l00);
    l11 = pivot_sqrt(fx_minus(a11, fx_times(l10, l10)));
    l21 = fx_over(fx_minus(from_signed(w.m21), fx_times(l20, l10)), l11);
    l22 = pivot_sqrt(fx_minus(fx_minus(a22, fx_times(l20, l20)), fx_times(l21, l21)));
    z0 = fx_over(from_signed(w.bx), l00);
    z1 = fx_over(fx_minus(from_signed(w.by), fx_times(l10, z0)), l11);
    z2 = fx_over(fx_minus(fx_minus(from_signed(w.bz), fx_times(l20, z0)),
                          fx_times(l21, z1)), l22);
    q2 = fx_over(z2, l22);
    q1 = fx_over(fx_minus(z1, fx_times(l21, q2)), l11);
    q0 = fx_over(fx_minus(fx_minus(z0, fx_times(l10, q1)), fx_times(l20, q2)), l00);
    s.y0 = to_signed(q0);
    s.y1 = to_signed(q1);
    s.y2 = to_signed(q2);
    s.ok = !step_saturated;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [W-1:0] rand_bits48();
    return W'({$urandom, $urandom});
  endfunction

  // Small signed value in [-2^k, 2^k).
  function automatic logic [W-1:0] rand_signed(int k);
    return W'(longint'({$urandom, $urandom} % (64'd1 << (k + 1))) - (longint'(1) << k));
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  // Sends one word after a gap of idle cycles; start is only lowered when a gap follows,
  // so that back-to-back words keep it high without a second assignment in one step.
  task automatic send_word(solve_word_t w, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    m00             <= w.m00;
    m11             <= w.m11;
    m22             <= w.m22;
    m10             <= w.m10;
    m20             <= w.m20;
    m21             <= w.m21;
    damping_squared <= w.damp;
    b_x             <= w.bx;
    b_y             <= w.by;
    b_z             <= w.bz;
    do @(posedge clk); while (busy);
    expected_solutions.push_back(cholesky_solve(w));
    words_sent++;
  endtask

  // Lets the pipeline empty out; used before a register write, in the drain pause and at the end.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_solutions.size() != 0) @(posedge clk);
  endtask

  task automatic write_floor(logic [FLOOR_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    floor_copy = value;
    floors_used++;
  endtask

  function automatic solve_word_t make_word(logic [W-1:0] a, logic [W-1:0] b, logic [W-1:0] c,
                                            logic [W-1:0] d, logic [W-1:0] e, logic [W-1:0] f,
                                            logic [W-2:0] dm, logic [W-1:0] x,
                                            logic [W-1:0] y, logic [W-1:0] z);
    solve_word_t w;
    w.m00 = a; w.m11 = b; w.m22 = c; w.m10 = d; w.m20 = e; w.m21 = f;
    w.damp = dm; w.bx = x; w.by = y; w.bz = z;
    return w;
  endfunction

  // A mostly well-conditioned system: positive diagonal with small off-diagonal terms.
  function automatic solve_word_t rand_spd_word();
    solve_word_t w;
    w.m00  = W'($urandom_range(1, 4096)) << F;
    w.m11  = W'($urandom_range(1, 4096)) << F;
    w.m22  = W'($urandom_range(1, 4096)) << F;
    w.m10  = rand_signed(18);
    w.m20  = rand_signed(18);
    w.m21  = rand_signed(18);
    w.damp = (W-1)'($urandom_range(0, 1 << 20));
    w.bx   = rand_signed($urandom_range(8, 40));
    w.by   = rand_signed($urandom_range(8, 40));
    w.bz   = rand_signed($urandom_range(8, 40));
    return w;
  endfunction

  // Raw noise across every bit of every field.
  function automatic solve_word_t rand_raw_word();
    return make_word(rand_bits48(), rand_bits48(), rand_bits48(), rand_bits48(),
                     rand_bits48(), rand_bits48(), (W-1)'(rand_bits48()),
                     rand_bits48(), rand_bits48(), rand_bits48());
  endfunction

  // ---------------------------------------------------------------------------
  // Named tests.
  // ---------------------------------------------------------------------------
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE  = W'(1) << F;

  task automatic test_directed();
    // Zero matrix: every pivot comes from the floor.
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
    // Identity with a plain right-hand side.
    send_word(make_word(ONE, ONE, ONE, 0, 0, 0, 0, 3 * ONE, -2 * ONE, ONE), 0);
    // Negative diagonal entries: non-positive pivots replaced by the floor.
    send_word(make_word(-ONE, -5 * ONE, VMIN, ONE, -ONE, ONE, 0, ONE, ONE, ONE), 1);
    // Field extremes, which saturate along the way.
    send_word(make_word(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, '1, VMAX, VMAX, VMAX), 0);
    send_word(make_word(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, '1, VMIN, VMIN, VMIN), 0);
    send_word(make_word(VMAX, VMIN, VMAX, VMIN, VMAX, VMIN, 0, VMIN, VMAX, VMIN), 3);
    // Large damping on a zero matrix.
    send_word(make_word(0, 0, 0, 0, 0, 0, '1, ONE, ONE, ONE), 0);
    // Tiny matrix with a huge right-hand side: division overflow.
    send_word(make_word(1, 1, 1, 0, 0, 0, 0, VMAX, VMIN, VMAX), 0);
    // Strong coupling: the second and third pivots go negative.
    send_word(make_word(ONE, ONE, ONE, 4 * ONE, 4 * ONE, 4 * ONE, 0, ONE, ONE, ONE), 0);
    send_word(make_word(4 * ONE, 9 * ONE, 16 * ONE, ONE, -ONE, 2 * ONE, ONE,
                        -7 * ONE, 5 * ONE, 11 * ONE), 2);
  endtask

  // Floor of zero, the largest in-range floor, the all-ones floor above that range, then back to one.
  task automatic test_floor_settings();
    logic [FLOOR_W-1:0] floors [4];
    floors[0] = 0;
    floors[1] = 17'd65536;
    floors[2] = '1;
    floors[3] = 17'd1;
    foreach (floors[i]) begin
      write_floor(floors[i]);
      send_word(make_word(0, 0, 0, 0, 0, 0, 0, ONE, -ONE, ONE), 0);
      send_word(make_word(-ONE, 3, -ONE, 1, 2, 3, 0, VMAX, 5, VMIN), 0);
      send_word(rand_spd_word(), 1);
    end
  endtask

  // Random phases with a fresh floor each time; most words are well conditioned.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        if ($urandom_range(0, 3) == 0) write_floor(FLOOR_W'($urandom));
        else write_floor(FLOOR_W'($urandom_range(1, 65536)));
      end
      // In some stretches the well-conditioned words run with no gaps at all.
      if ($urandom_range(0, 3) < 3) send_word(rand_spd_word(), (i % 40 < 15) ? 0 : rand_gap());
      else send_word(rand_raw_word(), rand_gap());
    end
  endtask

  // The sender holds off until every expected solution has arrived, then resumes.
  task automatic test_drain_pause();
    send_word(rand_spd_word(), 0);
    send_word(rand_spd_word(), 0);
    wait_drained();
    send_word(rand_spd_word(), 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    solution_t e;
    if (!rst && done) begin
      if (expected_solutions.size() == 0) begin
        $display("%0t: unexpected solution y0=%h y1=%h y2=%h valid=%b",
                 $time, y0, y1, y2, solution_valid);
        error_count++;
      end else begin
        e = expected_solutions.pop_front();
        if (y0 !== e.y0) begin
          $display("%0t: y0 expected %h actual %h", $time, e.y0, y0);
          error_count++;
        end
        if (y1 !== e.y1) begin
          $display("%0t: y1 expected %h actual %h", $time, e.y1, y1);
          error_count++;
        end
        if (y2 !== e.y2) begin
          $display("%0t: y2 expected %h actual %h", $time, e.y2, y2);
          error_count++;
        end
        if (solution_valid !== e.ok) begin
          $display("%0t: solution_valid expected %b actual %b", $time, e.ok, solution_valid);
          error_count++;
        end
        if (!e.ok) invalid_seen++;
        solutions_checked++;
      end
    end
  end

  // Watchdog: counts cycles in which no word, solution or register write is accepted.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d solutions outstanding",
               $time, expected_solutions.size());
      $display("FAIL damped_cholesky_solve_3x3_top");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    start             = 1'b0;
    m00               = '0;
    m11               = '0;
    m22               = '0;
    m10               = '0;
    m20               = '0;
    m21               = '0;
    damping_squared   = '0;
    b_x               = '0;
    b_y               = '0;
    b_z               = '0;
    cfg_valid         = 1'b0;
    cfg_data          = '0;
    floor_copy        = FLOOR_RESET;
    words_sent        = 0;
    solutions_checked = 0;
    invalid_seen      = 0;
    floors_used       = 0;
    error_count       = 0;
    idle_cycles       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words run with the reset floor, before any register write.
    test_directed();
    test_floor_settings();
    test_drain_pause();
    test_random(400);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words across %0d floor settings; checked %0d solutions, %0d saturated.",
             words_sent, floors_used, solutions_checked, invalid_seen);
    if (error_count == 0 && expected_solutions.size() == 0) begin
      $display("PASS damped_cholesky_solve_3x3_top");
    end else begin
      $display("%0d mismatches, %0d solutions missing", error_count,
               expected_solutions.size());
      $display("FAIL damped_cholesky_solve_3x3_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
